// ===== rtl/core/rle_pkg.sv =====
// rle_pkg: constants and command types shared by the run-length encoder
// used by the front end, the command queue and the back end
package rle_pkg;

    localparam int MAX_LITERAL = 32;
    localparam int LIT_CNT_W   = $clog2(MAX_LITERAL + 1);
    localparam int LIT_IDX_W   = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;

    localparam logic [6:0] RUN_LIMIT = 7'd126;
    localparam logic [6:0] MIN_RUN   = 7'd3;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_EMIT,
        CMD_LIT,
        CMD_FLUSH
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
        logic       last;
    } cmd_t;

endpackage

// ===== rtl/core/rle_stream_if.sv =====
// rle_stream_if: valid/ready channels for raw bytes and encoded bytes
// standalone, no package needed
interface rle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface rle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/core/rle_front.sv =====
// rle_front: tracks the pending run and turns each raw byte into up to three commands
// depends on rle_pkg and rle_in_if
module rle_front
    import rle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rle_in_if.sink      raw,
    output logic        push_valid,
    output cmd_t        push_cmd,
    input  logic        push_ready
);

    logic [7:0] run_value_reg, run_value_next;
    logic [6:0] run_count_reg, run_count_next;
    logic       started_reg, started_next;
    logic [1:0] pend_reg;
    cmd_t       list_reg [3];

    cmd_t       cmds [3];
    logic [1:0] n_cmds;
    logic       accept;
    logic       push;

    assign raw.ready  = (pend_reg == 2'd0);
    assign accept     = raw.valid && raw.ready;
    assign push_valid = (pend_reg != 2'd0);
    assign push_cmd   = list_reg[0];
    assign push       = push_valid && push_ready;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cmds[i] = '{op: CMD_FLUSH, data: 8'h00, last: 1'b0};
        end
        n_cmds         = 2'd0;
        run_value_next = run_value_reg;
        run_count_next = run_count_reg;
        started_next   = started_reg;

        if (accept)
        begin
            if (!started_reg)
            begin
                run_value_next = raw.data_byte;
                run_count_next = 7'd1;
                started_next   = 1'b1;
            end
            else if (raw.data_byte != run_value_reg || run_count_reg > RUN_LIMIT)
            begin
                // close the pending run
                if (run_count_reg >= MIN_RUN)
                begin
                    cmds[n_cmds] = '{op: CMD_EMIT, data: {1'b0, run_count_reg}, last: 1'b0};
                    n_cmds = n_cmds + 2'd1;
                    cmds[n_cmds] = '{op: CMD_EMIT, data: run_value_reg, last: 1'b0};
                    n_cmds = n_cmds + 2'd1;
                end
                else
                begin
                    if (run_count_reg == 7'd2)
                    begin
                        cmds[n_cmds] = '{op: CMD_LIT, data: run_value_reg, last: 1'b0};
                        n_cmds = n_cmds + 2'd1;
                    end
                    cmds[n_cmds] = '{op: CMD_LIT, data: run_value_reg, last: 1'b0};
                    n_cmds = n_cmds + 2'd1;
                end
                run_value_next = raw.data_byte;
                run_count_next = 7'd1;
            end
            else
            begin
                run_count_next = run_count_reg + 7'd1;
                if (run_count_next == MIN_RUN)
                begin
                    cmds[n_cmds] = '{op: CMD_FLUSH, data: 8'h00, last: 1'b0};
                    n_cmds = n_cmds + 2'd1;
                end
            end

            if (raw.stream_end)
            begin
                if (run_count_next >= MIN_RUN)
                begin
                    cmds[n_cmds] = '{op: CMD_EMIT, data: {1'b0, run_count_next}, last: 1'b0};
                    n_cmds = n_cmds + 2'd1;
                    cmds[n_cmds] = '{op: CMD_EMIT, data: run_value_next, last: 1'b1};
                    n_cmds = n_cmds + 2'd1;
                end
                else
                begin
                    if (run_count_next == 7'd2)
                    begin
                        cmds[n_cmds] = '{op: CMD_LIT, data: run_value_next, last: 1'b0};
                        n_cmds = n_cmds + 2'd1;
                    end
                    cmds[n_cmds] = '{op: CMD_LIT, data: run_value_next, last: 1'b1};
                    n_cmds = n_cmds + 2'd1;
                end
                run_value_next = 8'h00;
                run_count_next = 7'd0;
                started_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_value_reg <= 8'h00;
            run_count_reg <= 7'd0;
            started_reg   <= 1'b0;
            pend_reg      <= 2'd0;
        end
        else
        begin
            run_value_reg <= run_value_next;
            run_count_reg <= run_count_next;
            started_reg   <= started_next;
            if (accept)
            begin
                pend_reg <= n_cmds;
            end
            else if (push)
            begin
                pend_reg <= pend_reg - 2'd1;
            end
        end
    end

    // command list, shifted down on each transfer into the queue
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            list_reg <= cmds;
        end
        else if (push)
        begin
            list_reg[0] <= list_reg[1];
            list_reg[1] <= list_reg[2];
        end
    end

endmodule

// ===== rtl/core/rle_cmd_fifo.sv =====
// rle_cmd_fifo: short command queue between the front end and the back end
// depends on rle_pkg
module rle_cmd_fifo
    import rle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  cmd_t push_cmd,
    output logic push_ready,
    output logic pop_valid,
    output cmd_t pop_cmd,
    input  logic pop_ready
);

    cmd_t                 mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != CMD_CNT_W'(CMD_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + CMD_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + CMD_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CMD_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CMD_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/rle_back.sv =====
// rle_back: executes commands, owns the literal buffer and the output register
// depends on rle_pkg and rle_out_if
module rle_back
    import rle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    input  cmd_t       pop_cmd,
    output logic       pop_ready,
    rle_out_if.source  coded
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HDR,
        S_DATA
    } state_t;

    state_t               state_reg, state_next;
    logic [LIT_CNT_W-1:0] lit_cnt_reg, lit_cnt_next;
    logic [LIT_IDX_W-1:0] idx_reg, idx_next;
    logic                 flast_reg, flast_next;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;

    logic [7:0]           lit_mem [MAX_LITERAL];
    logic [7:0]           rd_data_reg;

    logic                 slot_free;
    logic                 wr_en;
    logic                 load;
    logic [7:0]           load_byte;
    logic                 load_last;
    logic [LIT_CNT_W-1:0] lit_inc;
    logic                 at_end;

    assign coded.valid    = out_valid_reg;
    assign coded.out_byte = out_byte_reg;
    assign coded.out_last = out_last_reg;

    assign slot_free = !out_valid_reg || coded.ready;
    assign lit_inc   = lit_cnt_reg + LIT_CNT_W'(1);
    assign at_end    = (LIT_CNT_W'(idx_reg) == lit_cnt_reg - LIT_CNT_W'(1));

    always_comb
    begin
        state_next   = state_reg;
        lit_cnt_next = lit_cnt_reg;
        idx_next     = idx_reg;
        flast_next   = flast_reg;
        pop_ready    = 1'b0;
        wr_en        = 1'b0;
        load         = 1'b0;
        load_byte    = 8'h00;
        load_last    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    case (pop_cmd.op)
                        CMD_EMIT:
                        begin
                            if (slot_free)
                            begin
                                pop_ready = 1'b1;
                                load      = 1'b1;
                                load_byte = pop_cmd.data;
                                load_last = pop_cmd.last;
                            end
                        end
                        CMD_LIT:
                        begin
                            pop_ready    = 1'b1;
                            wr_en        = 1'b1;
                            lit_cnt_next = lit_inc;
                            if (lit_inc == LIT_CNT_W'(MAX_LITERAL) || pop_cmd.last)
                            begin
                                state_next = S_HDR;
                                flast_next = pop_cmd.last;
                                idx_next   = '0;
                            end
                        end
                        CMD_FLUSH:
                        begin
                            pop_ready = 1'b1;
                            if (lit_cnt_reg != '0)
                            begin
                                state_next = S_HDR;
                                flast_next = 1'b0;
                                idx_next   = '0;
                            end
                        end
                        default:
                        begin
                            pop_ready = 1'b1;
                        end
                    endcase
                end
            end
            S_HDR:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    load_byte  = 8'd0 - 8'(lit_cnt_reg);
                    load_last  = 1'b0;
                    state_next = S_DATA;
                end
            end
            S_DATA:
            begin
                if (slot_free)
                begin
                    load      = 1'b1;
                    load_byte = rd_data_reg;
                    load_last = flast_reg && at_end;
                    if (at_end)
                    begin
                        lit_cnt_next = '0;
                        idx_next     = '0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + LIT_IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lit_cnt_reg   <= '0;
            idx_reg       <= '0;
            flast_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'h00;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lit_cnt_reg <= lit_cnt_next;
            idx_reg     <= idx_next;
            flast_reg   <= flast_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
                out_byte_reg  <= load_byte;
                out_last_reg  <= load_last;
            end
            else if (coded.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // literal buffer, read address follows the next index
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lit_mem[lit_cnt_reg[LIT_IDX_W-1:0]] <= pop_cmd.data;
        end
        rd_data_reg <= lit_mem[idx_next];
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lit_cnt_reg <= LIT_CNT_W'(MAX_LITERAL))
        else $error("literal count above buffer size");

    a_full_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (lit_cnt_reg != LIT_CNT_W'(MAX_LITERAL)))
        else $error("full literal buffer left unflushed");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DATA) |-> (LIT_CNT_W'(idx_reg) < lit_cnt_reg))
        else $error("literal index past buffer fill");

    a_hdr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HDR && slot_free) |=> (out_valid_reg && !out_last_reg))
        else $error("literal header marked as last");

endmodule

// ===== rtl/core/rle_byte_encoder.sv =====
// rle_byte_encoder: top level of the run-length byte encoder
// depends on rle_pkg, rle_stream_if, rle_front, rle_cmd_fifo and rle_back
//
// usage:
//   raw carries one byte per transfer with stream_end set on the final byte of a
//   stream; coded carries the encoded bytes, out_last set on the final one.
//   a run of 3 to 127 equal bytes becomes a length byte and the value; other
//   bytes collect in a 32-entry literal buffer sent as a negated count and the bytes.
//   the front end takes one raw byte and issues its commands, one per cycle
//   while the queue has room, up to three per byte; the next raw byte is
//   taken the cycle after the last command enters the 4-entry queue.
//   the back end sends at most one coded byte per cycle from its output
//   register, none while coded stalls; a literal flush of n bytes sends the
//   header byte, then the n bytes read through the single literal buffer port.
//   reset clears the run state, queue, literal count and output register;
//   the literal buffer is not cleared, no entry is read before it is written.
//   when coded stalls the output register holds, the back end stops once it
//   has a byte to send, the queue fills and raw ready drops; nothing is lost.
module rle_byte_encoder
    import rle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rle_in_if.sink     raw,
    rle_out_if.source  coded
);

    logic push_valid;
    cmd_t push_cmd;
    logic push_ready;
    logic pop_valid;
    cmd_t pop_cmd;
    logic pop_ready;

    rle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw        (raw),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    rle_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    rle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd),
        .pop_ready (pop_ready),
        .coded     (coded)
    );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for rle_byte_encoder, directed and random raw byte streams
// with an encoding scoreboard; needs rle_pkg, rle_stream_if and the encoder rtl

typedef struct packed {
    logic [7:0] val;
    logic       last;
} coded_byte_t;

class rle_scoreboard;
    logic [7:0]  run_value;
    logic [6:0]  run_count;
    logic [7:0]  lit_buf [rle_pkg::MAX_LITERAL];
    int          lit_count;
    bit          started;
    coded_byte_t coded_q [$];
    int          errors;
    int          checked;
    int          run_caps;
    int          full_flushes;

    function new();
        run_value    = '0;
        run_count    = '0;
        lit_count    = 0;
        started      = 0;
        errors       = 0;
        checked      = 0;
        run_caps     = 0;
        full_flushes = 0;
    endfunction

    function void put(logic [7:0] b);
        coded_byte_t c;
        c.val  = b;
        c.last = 1'b0;
        coded_q = {coded_q, c};
    endfunction

    function void emit_literals();
        if (lit_count == 0)
            return;
        put(8'(256 - lit_count));
        for (int i = 0; i < lit_count; i++)
            put(lit_buf[i]);
        lit_count = 0;
    endfunction

    function void add_literal(logic [7:0] b);
        if (lit_count < rle_pkg::MAX_LITERAL)
        begin
            lit_buf[lit_count] = b;
            lit_count++;
        end
        if (lit_count >= rle_pkg::MAX_LITERAL)
        begin
            full_flushes++;
            emit_literals();
        end
    endfunction

    function void close_run();
        if (run_count >= rle_pkg::MIN_RUN)
        begin
            put({1'b0, run_count});
            put(run_value);
        end
        else
        begin
            for (int i = 0; i < run_count; i++)
                add_literal(run_value);
        end
        run_count = '0;
    endfunction

    // predicts the coded bytes caused by one raw transfer
    function void note_raw(logic [7:0] d, logic stream_end);
        int first_idx;
        first_idx = coded_q.size();
        if (!started)
        begin
            run_value = d;
            run_count = 7'd1;
            lit_count = 0;
            started   = 1;
        end
        else if (d != run_value || run_count > rle_pkg::RUN_LIMIT)
        begin
            if (d == run_value)
                run_caps++;
            close_run();
            run_value = d;
            run_count = 7'd1;
        end
        else
        begin
            run_count = run_count + 7'd1;
            if (run_count == rle_pkg::MIN_RUN)
                emit_literals();
        end
        if (stream_end)
        begin
            close_run();
            emit_literals();
            if (coded_q.size() > first_idx)
                coded_q[coded_q.size() - 1].last = 1'b1;
            run_value = '0;
            run_count = '0;
            lit_count = 0;
            started   = 0;
        end
    endfunction

    task report(string msg);
        errors++;
        $display("[%0t] coded byte %0d: %s", $time, checked, msg);
    endtask

    task check_coded(logic [7:0] b, logic last);
        coded_byte_t c;
        if (coded_q.size() == 0)
        begin
            report($sformatf("unexpected transfer %02h last %0b", b, last));
        end
        else
        begin
            c = coded_q.pop_front();
            if (b !== c.val)
                report($sformatf("out_byte %02h, want %02h", b, c.val));
            if (last !== c.last)
                report($sformatf("out_last %0b, want %0b", last, c.last));
        end
        checked++;
    endtask
endclass

module tb_top;
    import rle_pkg::*;

    localparam int RAW_ITEMS    = 470;
    localparam int TAIL_ITEMS   = 80;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;

    rle_in_if  raw_ch ();
    rle_out_if coded_ch ();

    rle_byte_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_ch),
        .coded (coded_ch)
    );

    rle_scoreboard sb;
    logic [7:0]    stream_q [$];
    int            sent;
    int            raw_count;
    int            streams;
    int            cycles;
    bit            tail;
    bit            held;
    int            hold_left;
    int            stall_left;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (raw_ch.valid && raw_ch.ready)
            begin
                sb.note_raw(raw_ch.data_byte, raw_ch.stream_end);
                raw_count++;
            end
            if (coded_ch.valid && coded_ch.ready)
                sb.check_coded(coded_ch.out_byte, coded_ch.out_last);
        end
    end

    // coded side: random stalls, one long hold-off in the middle
    initial
    begin
        coded_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && raw_count >= 200)
            begin
                held      = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                coded_ch.ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                coded_ch.ready = 1'b0;
            end
            else if (!tail && (cycles % 600) < 450 && $urandom_range(0, 4) == 0)
            begin
                stall_left     = $urandom_range(1, 9) - 1;
                coded_ch.ready = 1'b0;
            end
            else
            begin
                coded_ch.ready = 1'b1;
            end
        end
    end

    task automatic send_raw(input logic [7:0] b, input logic stream_end);
        int gap;
        @(negedge clk);
        tail = (sent >= RAW_ITEMS - TAIL_ITEMS);
        if (!tail && (sent % 64) < 44 && $urandom_range(0, 3) == 0)
        begin
            gap          = $urandom_range(1, 9);
            raw_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        raw_ch.valid      = 1'b1;
        raw_ch.data_byte  = b;
        raw_ch.stream_end = stream_end;
        @(posedge clk);
        while (!raw_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_q.size(); i++)
            send_raw(stream_q[i], i == stream_q.size() - 1);
        stream_q.delete();
        streams++;
    endtask

    function automatic void add_run(logic [7:0] v, int n);
        repeat (n) stream_q = {stream_q, v};
    endfunction

    // consecutive bytes always differ
    function automatic void add_literals(int n);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        repeat (n)
        begin
            stream_q = {stream_q, b};
            b = b + 8'($urandom_range(1, 255));
        end
    endfunction

    function automatic void build_random_stream();
        int segs;
        int kind;
        segs = $urandom_range(1, 10);
        repeat (segs)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 50)
                add_run(8'($urandom_range(0, 255)), $urandom_range(1, 4));
            else if (kind < 65)
                add_run(8'($urandom_range(0, 255)), $urandom_range(3, 12));
            else if (kind < 85)
                add_literals($urandom_range(2, 12));
            else if (kind < 90)
                add_literals($urandom_range(30, 40));
            else if (stream_q.size() > 0)
                add_run(stream_q[stream_q.size() - 1], $urandom_range(1, 3));
            else
                add_run(8'($urandom_range(0, 255)), 1);
        end
    endfunction

    initial
    begin
        sb                = new();
        rst_n             = 1'b0;
        raw_ch.valid      = 1'b0;
        raw_ch.data_byte  = 8'h00;
        raw_ch.stream_end = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single-byte streams at both extremes
        add_run(8'h00, 1);
        send_stream();
        add_run(8'hff, 1);
        send_stream();
        // bare run of three
        add_run(8'ha5, 3);
        send_stream();
        // two literals closed by stream end
        add_run(8'h12, 1);
        add_run(8'h34, 1);
        send_stream();
        // literals flushed when a run reaches three, trailing literal
        add_run(8'h01, 1);
        add_run(8'h02, 1);
        add_run(8'h07, 4);
        add_run(8'h80, 1);
        send_stream();
        // short run folded into the literal buffer
        add_run(8'h5a, 2);
        add_run(8'h3c, 1);
        send_stream();
        add_run(8'h55, 1);
        add_run(8'haa, 1);
        add_run(8'h55, 1);
        add_run(8'haa, 1);
        send_stream();

        // full literal buffer, then a run past the length cap
        add_literals(33);
        add_run(8'($urandom_range(0, 255)), 128);
        send_stream();

        while (sent < RAW_ITEMS)
        begin
            build_random_stream();
            send_stream();
        end
        @(negedge clk);
        raw_ch.valid = 1'b0;

        while (sb.coded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d streams, %0d raw bytes, %0d coded bytes checked",
                 streams, raw_count, sb.checked);
        $display("capped runs %0d, full literal flushes %0d, hold-off %0d cycles",
                 sb.run_caps, sb.full_flushes, HOLD_CYCLES);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
